@@ hw/rtl/swhf_pkg.sv @@
// Shared types, constants and saturating fixed-point helpers for the HLLC flux block.
package swhf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [30:0] GRAVITY_RESET = 31'd642908;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7fff_ffff;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // One interface: both sides plus g*h of each side
    typedef struct packed {
        q_t hl;
        q_t ul;
        q_t vl;
        q_t hr;
        q_t ur;
        q_t vr;
        q_t ghl;
        q_t ghr;
    } iface_t;

    // What the output stage needs besides the quotients
    typedef struct packed {
        q_t   vl;
        q_t   vr;
        q_t   fl0;
        q_t   fl1;
        q_t   fl2;
        q_t   fr0;
        q_t   fr1;
        q_t   fr2;
        logic sel_left;
        logic sel_right;
        logic zero_div;
    } tail_t;

    function automatic q_t sat64(input logic signed [63:0] v);
        if (v > 64'(Q_MAX))
            return Q_MAX;
        else if (v < 64'(Q_MIN))
            return Q_MIN;
        else
            return v[31:0];
    endfunction

    function automatic q_t sadd(input q_t a, input q_t b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat64(s);
    endfunction

    function automatic q_t ssub(input q_t a, input q_t b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat64(s);
    endfunction

    // Product shifted right with rounding toward minus infinity, saturated
    function automatic q_t qmul(input q_t a, input q_t b, input int frac);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat64(p >>> frac);
    endfunction

    // floor((a+b)/2) of the exact sum
    function automatic q_t hsum(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        s = s >>> 1;
        return s[31:0];
    endfunction

    // floor((a-b)/4) of the exact difference
    function automatic q_t quarter(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        s = s >>> 2;
        return s[31:0];
    endfunction

endpackage

@@ hw/rtl/swhf_sqrt.sv @@
// Pipelined fixed-point square root, one root bit per stage, with a side band.
module swhf_sqrt
    import swhf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANES     = 2,
    parameter int SIDE_W    = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [30:0]       x [LANES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output q_t                root [LANES],
    output logic [SIDE_W-1:0] out_side
);

    localparam int RW = (33 + FRAC_BITS) / 2;
    localparam int VW = 2 * RW;

    logic [VW-1:0]     rad_reg  [0:RW][LANES];
    logic [RW+1:0]     rem_reg  [0:RW][LANES];
    logic [RW-1:0]     root_reg [0:RW][LANES];
    logic [VW-1:0]     rad_next [0:RW][LANES];
    logic [RW+1:0]     rem_next [0:RW][LANES];
    logic [RW-1:0]     root_next[0:RW][LANES];
    logic [SIDE_W-1:0] side_reg [0:RW];
    logic              valid_reg[0:RW];

    // Load radicand x * 2^FRAC_BITS
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rad_next[0][l]  = VW'({x[l], {FRAC_BITS{1'b0}}});
            rem_next[0][l]  = '0;
            root_next[0][l] = '0;
        end
    end

    // One restoring step per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_step
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [RW+3:0] r4;
            logic [RW+3:0] trial;
            always_comb
            begin
                r4    = {rem_reg[k][l], rad_reg[k][l][VW-1:VW-2]};
                trial = (RW+4)'({root_reg[k][l], 2'b01});
                rad_next[k+1][l] = {rad_reg[k][l][VW-3:0], 2'b00};
                if (r4 >= trial)
                begin
                    rem_next[k+1][l]  = (RW+2)'(r4 - trial);
                    root_next[k+1][l] = {root_reg[k][l][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k+1][l]  = r4[RW+1:0];
                    root_next[k+1][l] = {root_reg[k][l][RW-2:0], 1'b0};
                end
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RW; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < RW; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < RW; k++)
                side_reg[k+1] <= side_reg[k];
            for (int k = 0; k <= RW; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rad_reg[k][l]  <= rad_next[k][l];
                    rem_reg[k][l]  <= rem_next[k][l];
                    root_reg[k][l] <= root_next[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            root[l] = q_t'(root_reg[RW][l]);
    end

    assign out_valid = valid_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

@@ hw/rtl/swhf_div.sv @@
// Pipelined signed fixed-point divider, one quotient bit per stage, with a side band.
module swhf_div
    import swhf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANES     = 3,
    parameter int SIDE_W    = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  q_t                num [LANES],
    input  q_t                den [LANES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output q_t                quot [LANES],
    output logic [SIDE_W-1:0] out_side
);

    localparam int NW = 32 + FRAC_BITS;

    logic [NW-1:0]     work_reg [0:NW][LANES];
    logic [31:0]       rem_reg  [0:NW][LANES];
    logic [31:0]       dvs_reg  [0:NW][LANES];
    logic              neg_reg  [0:NW][LANES];
    logic [NW-1:0]     work_next[0:NW][LANES];
    logic [31:0]       rem_next [0:NW][LANES];
    logic [SIDE_W-1:0] side_reg [0:NW];
    logic              valid_reg[0:NW];

    // Load magnitudes; numerator scaled by 2^FRAC_BITS
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [31:0] mag_n;
            mag_n = num[l][31] ? (~num[l] + 32'd1) : num[l];
            work_next[0][l] = NW'({mag_n, {FRAC_BITS{1'b0}}});
            rem_next[0][l]  = '0;
        end
    end

    // One restoring step per stage
    for (genvar k = 0; k < NW; k++)
    begin : g_step
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [32:0] r2;
            logic        ge;
            always_comb
            begin
                r2 = {rem_reg[k][l], work_reg[k][l][NW-1]};
                ge = (r2 >= {1'b0, dvs_reg[k][l]});
                rem_next[k+1][l]  = ge ? 32'(r2 - {1'b0, dvs_reg[k][l]}) : r2[31:0];
                work_next[k+1][l] = {work_reg[k][l][NW-2:0], ge};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < NW; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int l = 0; l < LANES; l++)
            begin
                dvs_reg[0][l] <= den[l][31] ? (~den[l] + 32'd1) : den[l];
                neg_reg[0][l] <= num[l][31] ^ den[l][31];
            end
            for (int k = 0; k < NW; k++)
            begin
                side_reg[k+1] <= side_reg[k];
                for (int l = 0; l < LANES; l++)
                begin
                    dvs_reg[k+1][l] <= dvs_reg[k][l];
                    neg_reg[k+1][l] <= neg_reg[k][l];
                end
            end
            for (int k = 0; k <= NW; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    work_reg[k][l] <= work_next[k][l];
                    rem_reg[k][l]  <= rem_next[k][l];
                end
            end
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [NW-1:0] q;
            q = work_reg[NW][l];
            if (neg_reg[NW][l])
                quot[l] = (q > NW'(33'h0_8000_0000)) ? Q_MIN : 32'(~q + NW'(1));
            else
                quot[l] = (q > NW'(33'h0_7fff_ffff)) ? Q_MAX : q[31:0];
        end
    end

    assign out_valid = valid_reg[NW];
    assign out_side  = side_reg[NW];

endmodule

@@ hw/rtl/swhf_speeds.sv @@
// Wave speeds, point fluxes and star-state numerators over eight register stages.
module swhf_speeds
    import swhf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  iface_t in_d,
    input  q_t     cl,
    input  q_t     cr,
    output logic   out_valid,
    output tail_t  out_tail,
    output q_t     num [3],
    output q_t     den [3]
);

    typedef struct packed {
        iface_t d;
        q_t cl; q_t cr; q_t ustar_a; q_t cstar; q_t cl2; q_t cr2;
        q_t al; q_t ar; q_t uul; q_t uur; q_t hul; q_t hur;
    } s1_t;

    typedef struct packed {
        iface_t d;
        q_t cstar; q_t al; q_t ar; q_t hul; q_t hur; q_t ustar;
        q_t sldry; q_t srdry; q_t pl; q_t pr; q_t f2l; q_t f2r;
    } s2_t;

    typedef struct packed {
        iface_t d;
        q_t al; q_t ar; q_t hul; q_t hur; q_t sldry; q_t srdry;
        q_t f2l; q_t f2r; q_t b; q_t b2; q_t f1l; q_t f1r;
    } s3_t;

    typedef struct packed {
        iface_t d;
        q_t hul; q_t hur; q_t f2l; q_t f2r; q_t f1l; q_t f1r; q_t sl; q_t sr;
    } s4_t;

    typedef struct packed {
        iface_t d;
        q_t hul; q_t hur; q_t f2l; q_t f2r; q_t f1l; q_t f1r; q_t sl; q_t sr;
        q_t den; q_t tr; q_t tl; q_t dhr; q_t dhu;
        logic sel_left; logic sel_right;
    } s5_t;

    typedef struct packed {
        tail_t tail;
        q_t den; q_t tr; q_t tl; q_t dhr; q_t dhu;
        q_t slsr; q_t dr; q_t dl; q_t m1; q_t m2; q_t m3; q_t m4; q_t n5; q_t n6;
    } s6_t;

    typedef struct packed {
        tail_t tail;
        q_t den; q_t smden; q_t a0; q_t a1; q_t k0; q_t k1; q_t q5; q_t q6;
    } s7_t;

    typedef struct packed {
        tail_t tail;
        q_t num0; q_t num1; q_t nums; q_t den; q_t smden;
    } s8_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;
    logic [8:1] valid_reg;

    // Star estimates, doubled celerities, squares and momenta
    always_comb
    begin
        s1_next.d       = in_d;
        s1_next.cl      = cl;
        s1_next.cr      = cr;
        s1_next.ustar_a = sadd(hsum(in_d.ul, in_d.ur), cl);
        s1_next.cstar   = sadd(hsum(cl, cr), quarter(in_d.ul, in_d.ur));
        s1_next.cl2     = sadd(cl, cl);
        s1_next.cr2     = sadd(cr, cr);
        s1_next.al      = ssub(in_d.ul, cl);
        s1_next.ar      = sadd(in_d.ur, cr);
        s1_next.uul     = qmul(in_d.ul, in_d.ul, FRAC_BITS);
        s1_next.uur     = qmul(in_d.ur, in_d.ur, FRAC_BITS);
        s1_next.hul     = qmul(in_d.hl, in_d.ul, FRAC_BITS);
        s1_next.hur     = qmul(in_d.hr, in_d.ur, FRAC_BITS);
    end

    // Dry-bed speeds, pressure terms, transverse point fluxes
    always_comb
    begin
        s2_next.d     = s1_reg.d;
        s2_next.cstar = s1_reg.cstar;
        s2_next.al    = s1_reg.al;
        s2_next.ar    = s1_reg.ar;
        s2_next.hul   = s1_reg.hul;
        s2_next.hur   = s1_reg.hur;
        s2_next.ustar = ssub(s1_reg.ustar_a, s1_reg.cr);
        s2_next.sldry = ssub(s1_reg.d.ur, s1_reg.cr2);
        s2_next.srdry = sadd(s1_reg.d.ul, s1_reg.cl2);
        s2_next.pl    = sadd(s1_reg.uul, s1_reg.d.ghl >>> 1);
        s2_next.pr    = sadd(s1_reg.uur, s1_reg.d.ghr >>> 1);
        s2_next.f2l   = qmul(s1_reg.hul, s1_reg.d.vl, FRAC_BITS);
        s2_next.f2r   = qmul(s1_reg.hur, s1_reg.d.vr, FRAC_BITS);
    end

    // Star wave speeds, normal momentum point fluxes
    always_comb
    begin
        s3_next.d     = s2_reg.d;
        s3_next.al    = s2_reg.al;
        s3_next.ar    = s2_reg.ar;
        s3_next.hul   = s2_reg.hul;
        s3_next.hur   = s2_reg.hur;
        s3_next.sldry = s2_reg.sldry;
        s3_next.srdry = s2_reg.srdry;
        s3_next.f2l   = s2_reg.f2l;
        s3_next.f2r   = s2_reg.f2r;
        s3_next.b     = ssub(s2_reg.ustar, s2_reg.cstar);
        s3_next.b2    = sadd(s2_reg.ustar, s2_reg.cstar);
        s3_next.f1l   = qmul(s2_reg.d.hl, s2_reg.pl, FRAC_BITS);
        s3_next.f1r   = qmul(s2_reg.d.hr, s2_reg.pr, FRAC_BITS);
    end

    // Pick outer wave speeds
    always_comb
    begin
        s4_next.d   = s3_reg.d;
        s4_next.hul = s3_reg.hul;
        s4_next.hur = s3_reg.hur;
        s4_next.f2l = s3_reg.f2l;
        s4_next.f2r = s3_reg.f2r;
        s4_next.f1l = s3_reg.f1l;
        s4_next.f1r = s3_reg.f1r;
        if (s3_reg.d.hl == 0)
            s4_next.sl = s3_reg.sldry;
        else
            s4_next.sl = (s3_reg.al < s3_reg.b) ? s3_reg.al : s3_reg.b;
        if (s3_reg.d.hr == 0)
            s4_next.sr = s3_reg.srdry;
        else
            s4_next.sr = (s3_reg.ar > s3_reg.b2) ? s3_reg.ar : s3_reg.b2;
    end

    // Differences and upwind decisions
    always_comb
    begin
        s5_next.d         = s4_reg.d;
        s5_next.hul       = s4_reg.hul;
        s5_next.hur       = s4_reg.hur;
        s5_next.f2l       = s4_reg.f2l;
        s5_next.f2r       = s4_reg.f2r;
        s5_next.f1l       = s4_reg.f1l;
        s5_next.f1r       = s4_reg.f1r;
        s5_next.sl        = s4_reg.sl;
        s5_next.sr        = s4_reg.sr;
        s5_next.den       = ssub(s4_reg.sr, s4_reg.sl);
        s5_next.tr        = ssub(s4_reg.d.ur, s4_reg.sr);
        s5_next.tl        = ssub(s4_reg.d.ul, s4_reg.sl);
        s5_next.dhr       = ssub(s4_reg.d.hr, s4_reg.d.hl);
        s5_next.dhu       = ssub(s4_reg.hur, s4_reg.hul);
        s5_next.sel_left  = (s4_reg.sl >= 0);
        s5_next.sel_right = (s4_reg.sr <= 0);
    end

    // First row of star products
    always_comb
    begin
        s6_next.tail.vl        = s5_reg.d.vl;
        s6_next.tail.vr        = s5_reg.d.vr;
        s6_next.tail.fl0       = s5_reg.hul;
        s6_next.tail.fl1       = s5_reg.f1l;
        s6_next.tail.fl2       = s5_reg.f2l;
        s6_next.tail.fr0       = s5_reg.hur;
        s6_next.tail.fr1       = s5_reg.f1r;
        s6_next.tail.fr2       = s5_reg.f2r;
        s6_next.tail.sel_left  = s5_reg.sel_left;
        s6_next.tail.sel_right = s5_reg.sel_right;
        s6_next.tail.zero_div  = 1'b0;
        s6_next.den  = s5_reg.den;
        s6_next.tr   = s5_reg.tr;
        s6_next.tl   = s5_reg.tl;
        s6_next.dhr  = s5_reg.dhr;
        s6_next.dhu  = s5_reg.dhu;
        s6_next.slsr = qmul(s5_reg.sl, s5_reg.sr, FRAC_BITS);
        s6_next.dr   = qmul(s5_reg.d.hr, s5_reg.tr, FRAC_BITS);
        s6_next.dl   = qmul(s5_reg.d.hl, s5_reg.tl, FRAC_BITS);
        s6_next.m1   = qmul(s5_reg.sr, s5_reg.hul, FRAC_BITS);
        s6_next.m2   = qmul(s5_reg.sl, s5_reg.hur, FRAC_BITS);
        s6_next.m3   = qmul(s5_reg.sr, s5_reg.f1l, FRAC_BITS);
        s6_next.m4   = qmul(s5_reg.sl, s5_reg.f1r, FRAC_BITS);
        s6_next.n5   = qmul(s5_reg.sl, s5_reg.d.hr, FRAC_BITS);
        s6_next.n6   = qmul(s5_reg.sr, s5_reg.d.hl, FRAC_BITS);
    end

    // Second row of star products
    always_comb
    begin
        s7_next.tail  = s6_reg.tail;
        s7_next.den   = s6_reg.den;
        s7_next.smden = ssub(s6_reg.dr, s6_reg.dl);
        s7_next.a0    = ssub(s6_reg.m1, s6_reg.m2);
        s7_next.a1    = ssub(s6_reg.m3, s6_reg.m4);
        s7_next.k0    = qmul(s6_reg.slsr, s6_reg.dhr, FRAC_BITS);
        s7_next.k1    = qmul(s6_reg.slsr, s6_reg.dhu, FRAC_BITS);
        s7_next.q5    = qmul(s6_reg.n5, s6_reg.tr, FRAC_BITS);
        s7_next.q6    = qmul(s6_reg.n6, s6_reg.tl, FRAC_BITS);
    end

    // Numerators and zero-divisor flag
    always_comb
    begin
        s8_next.tail          = s7_reg.tail;
        s8_next.tail.zero_div = (s7_reg.den == 0) || (s7_reg.smden == 0);
        s8_next.num0          = sadd(s7_reg.a0, s7_reg.k0);
        s8_next.num1          = sadd(s7_reg.a1, s7_reg.k1);
        s8_next.nums          = ssub(s7_reg.q5, s7_reg.q6);
        s8_next.den           = s7_reg.den;
        s8_next.smden         = s7_reg.smden;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[7:1], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
        end
    end

    assign out_valid = valid_reg[8];
    assign out_tail  = s8_reg.tail;
    assign num[0]    = s8_reg.num0;
    assign num[1]    = s8_reg.num1;
    assign num[2]    = s8_reg.nums;
    assign den[0]    = s8_reg.den;
    assign den[1]    = s8_reg.den;
    assign den[2]    = s8_reg.smden;

endmodule

@@ hw/rtl/shallow_water_hllc_flux.sv @@
// HLLC shallow-water flux: one interface word in, one flux word out, fully pipelined.
// The block takes one interface word per clock and gives one flux word per clock while its
// output is taken. Each word passes through the g*h register, a square-root pipeline of one
// root bit per stage, the wave-speed and flux arithmetic, a divider pipeline of one quotient
// bit per stage (32 + FRAC_BITS stages) and the output register. The whole pipe halts while
// a finished word is not taken. Gravity is written through the cfg port; the user must do so
// only while the pipe is empty, which the block itself does not enforce. It resets to 9.81.
// Status 2 marks a zero divisor on a star-state word, with all fluxes zero.
module shallow_water_hllc_flux
    import swhf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_depth[30:0], left_u[62:31], left_v[94:63],
    // right_depth[125:95], right_u[157:126], right_v[189:158]
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mass_flux[31:0], normal_momentum_flux[63:32], transverse_momentum_flux[95:64]
    output logic [95:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data
);

    logic        en;
    logic [30:0] gravity_reg;
    logic        a_valid_reg;
    iface_t      a_reg, a_next;
    logic        sq_valid;
    logic [30:0] sq_x [2];
    q_t          sq_root [2];
    logic [$bits(iface_t)-1:0] sq_side;
    logic        sp_valid;
    tail_t       sp_tail;
    q_t          sp_num [3];
    q_t          sp_den [3];
    logic        dv_valid;
    q_t          dv_quot [3];
    logic [$bits(tail_t)-1:0] dv_side;
    tail_t       tail;
    logic        m_valid_reg;
    logic [95:0] m_data_reg, m_data_next;
    logic [1:0]  m_status_reg, m_status_next;

    // Halt every stage while the output word waits
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Hold gravity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (cfg_valid)
            gravity_reg <= cfg_data;
    end

    // Unpack and form g*h of each side
    always_comb
    begin
        a_next.hl  = q_t'({1'b0, s_tdata[30:0]});
        a_next.ul  = s_tdata[62:31];
        a_next.vl  = s_tdata[94:63];
        a_next.hr  = q_t'({1'b0, s_tdata[125:95]});
        a_next.ur  = s_tdata[157:126];
        a_next.vr  = s_tdata[189:158];
        a_next.ghl = qmul(q_t'({1'b0, gravity_reg}), a_next.hl, FRAC_BITS);
        a_next.ghr = qmul(q_t'({1'b0, gravity_reg}), a_next.hr, FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= a_next;
    end

    assign sq_x[0] = a_reg.ghl[30:0];
    assign sq_x[1] = a_reg.ghr[30:0];

    swhf_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .LANES     (2),
        .SIDE_W    ($bits(iface_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .x         (sq_x),
        .in_side   (a_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    swhf_speeds #(
        .FRAC_BITS (FRAC_BITS)
    ) u_speeds (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_d      (iface_t'(sq_side)),
        .cl        (sq_root[0]),
        .cr        (sq_root[1]),
        .out_valid (sp_valid),
        .out_tail  (sp_tail),
        .num       (sp_num),
        .den       (sp_den)
    );

    swhf_div #(
        .FRAC_BITS (FRAC_BITS),
        .LANES     (3),
        .SIDE_W    ($bits(tail_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sp_valid),
        .num       (sp_num),
        .den       (sp_den),
        .in_side   (sp_tail),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    assign tail = tail_t'(dv_side);

    // Pick upwind, zero or star flux; split transverse term at the contact
    always_comb
    begin
        q_t f0;
        q_t f1;
        q_t f2;
        f0            = '0;
        f1            = '0;
        f2            = '0;
        m_status_next = ST_OK;
        priority if (tail.sel_left)
        begin
            f0 = tail.fl0;
            f1 = tail.fl1;
            f2 = tail.fl2;
        end
        else if (tail.sel_right)
        begin
            f0 = tail.fr0;
            f1 = tail.fr1;
            f2 = tail.fr2;
        end
        else if (tail.zero_div)
        begin
            m_status_next = ST_ZERO_DIV;
        end
        else
        begin
            f0 = dv_quot[0];
            f1 = dv_quot[1];
            priority if (dv_quot[2] >= 0)
                f2 = qmul(tail.vl, dv_quot[0], FRAC_BITS);
            else if (dv_quot[2] <= 0)
                f2 = qmul(tail.vr, dv_quot[0], FRAC_BITS);
            else
                m_status_next = ST_OUTSIDE;
        end
        m_data_next = {f2, f1, f0};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // A zero-divisor word carries zero fluxes
    a_zero_div_fluxes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_ZERO_DIV) |-> (m_tdata == '0))
        else $error("zero-divisor word with nonzero flux");

    // A config write lands in the gravity register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (gravity_reg == $past(cfg_data)))
        else $error("gravity write lost");

    // An accepted word enters the first stage
    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> a_valid_reg)
        else $error("accepted word dropped at entry");

endmodule
